FILE: rtl/fbt_pkg.sv
package fbt_pkg;

  localparam int KEY_W  = 64;
  localparam int SIZE_W = 24;
  localparam int HITS_W = 5;
  localparam int EVC_W  = 5;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = '1;

  // One table entry as it sits in the entry memory.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] length;
    logic [SIZE_W-1:0] offset;
    logic [HITS_W-1:0] hits;
  } ent_t;

  // One result beat.
  typedef struct packed {
    logic              hit;
    logic              stored;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] length;
    logic [EVC_W-1:0]  evictions;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_LOOK  = 2'd0,
    OP_BUMP  = 2'd1,
    OP_AGE   = 2'd2,
    OP_SHIFT = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    ent_t              entry;
    logic [KEY_W-1:0]  key;
    logic [HITS_W-1:0] bound;
    logic [SIZE_W-1:0] shift;
  } alu_in_t;

  typedef struct packed {
    logic match;
    logic less;
    ent_t entry;
  } alu_out_t;

endpackage

FILE: rtl/fbt_req_if.sv
interface fbt_req_if;
  import fbt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] block_size;
  logic              keep_flag;
  logic              no_evict;

  modport source (output valid, key, block_size, keep_flag, no_evict, input ready);
  modport sink (input valid, key, block_size, keep_flag, no_evict, output ready);
endinterface

FILE: rtl/fbt_rsp_if.sv
interface fbt_rsp_if;
  import fbt_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic              stored;
  logic [SIZE_W-1:0] offset;
  logic [SIZE_W-1:0] length;
  logic [EVC_W-1:0]  evictions;

  modport source (output valid, hit, stored, offset, length, evictions, input ready);
  modport sink (input valid, hit, stored, offset, length, evictions, output ready);
endinterface

FILE: rtl/frequency_evicting_buffer_table_core.sv
// Channel   Direction  Beat contents
// req_i     in         key, block_size, keep_flag, no_evict
// rsp_o     out        hit, stored, offset, length, evictions
// APB       in/out     capacity register at byte address 0
//
// A request walks the valid entries through one memory read port, one entry per cycle: a
// missed lookup reads every valid entry, each eviction adds a minimum scan and a
// compaction pass, an append adds a write, and the output hand-off follows. The request
// port is ready only in the idle state; a finished result sits in an output register, so
// the next request is taken while it waits. Reset is asynchronous and active low; it
// empties the table and restores the full capacity.
module frequency_evicting_buffer_table_core #(
  parameter int TABLE_ENTRIES = 16,
  parameter int HIT_CEILING   = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fbt_req_if.sink                            req_i,
  fbt_rsp_if.source                          rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fbt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fbt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fbt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import fbt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // The sequencer steps through lookup, eviction and append phases.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOK   = 8'b0000_0010,
    S_BUMP   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_SHIFT  = 8'b0010_0000,
    S_APPEND = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     vcnt_q, vcnt_d;
  logic [SIZE_W-1:0] used_q, used_d;
  logic [SIZE_W-1:0] cap_q;
  logic [CW-1:0]     k_q, k_d;
  logic              pend_q, pend_d;
  logic              outv_q, outv_d;

  logic [KEY_W-1:0]  key_q, key_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              keep_q, keep_d;
  logic              noev_q, noev_d;
  logic [CW-1:0]     pidx_q, pidx_d;
  logic [HITS_W-1:0] best_q, best_d;
  logic [CW-1:0]     vic_q, vic_d;
  logic [SIZE_W-1:0] vsize_q, vsize_d;
  logic [IW-1:0]     hidx_q, hidx_d;
  ent_t              ent_q, ent_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;

  logic              cfg_wr;
  logic              walking;
  logic [CW-1:0]     issue_lim;
  logic              issue;
  logic [CW-1:0]     raddr_w;
  logic [SIZE_W-1:0] free_space;
  logic              short;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  ent_t              mem_wdata;
  ent_t              mem_rdata;

  alu_in_t           alu_in;
  alu_out_t          alu_out;

  // Configuration port. Write the capacity only while the block is idle (not enforced).
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_CAPACITY) ?
                  {{(APB_DATA_W - SIZE_W){1'b0}}, cap_q} : '0;

  // Free space counts as zero once capacity has been lowered below the fill.
  assign free_space = (cap_q > used_q) ? cap_q - used_q : '0;
  assign short      = (free_space < size_q);

  // The walk streams one read per cycle; the data for index pidx_q comes back
  // in the cycle after its read. During compaction, entries at or above the victim
  // read their upper neighbor, which collapses the gap.
  assign walking   = (state_q == S_LOOK) || (state_q == S_SCAN) || (state_q == S_SHIFT);
  assign issue_lim = (state_q == S_SHIFT) ? vcnt_q - CW'(1) : vcnt_q;
  assign issue     = walking && (k_q < issue_lim);
  assign raddr_w   = (state_q == S_SHIFT) ? k_q + CW'(k_q >= vic_q) : k_q;

  fbt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (raddr_w[IW-1:0]),
    .rdata_o (mem_rdata)
  );

  // The shared unit matches keys, ranks hit counts and rewrites entries.
  always_comb begin
    alu_in.entry = mem_rdata;
    alu_in.key   = key_q;
    alu_in.bound = best_q;
    alu_in.shift = vsize_q;
    alu_in.op    = OP_LOOK;
    case (state_q)
      S_BUMP: begin
        alu_in.entry = ent_q;
        alu_in.op    = OP_BUMP;
      end
      S_SHIFT: begin
        alu_in.op = (pidx_q >= vic_q) ? OP_SHIFT : OP_AGE;
      end
      default: begin
        alu_in.op = OP_LOOK;
      end
    endcase
  end

  fbt_alu #(
    .HIT_CEILING (HIT_CEILING)
  ) u_alu (
    .in_i  (alu_in),
    .out_o (alu_out)
  );

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = outv_q;
  assign rsp_o.hit       = out_q.hit;
  assign rsp_o.stored    = out_q.stored;
  assign rsp_o.offset    = out_q.offset;
  assign rsp_o.length    = out_q.length;
  assign rsp_o.evictions = out_q.evictions;

  always_comb begin
    state_d   = state_q;
    vcnt_d    = vcnt_q;
    used_d    = used_q;
    k_d       = issue ? k_q + CW'(1) : k_q;
    pend_d    = issue;
    pidx_d    = k_q;
    outv_d    = outv_q & ~rsp_o.ready;
    key_d     = key_q;
    size_d    = size_q;
    keep_d    = keep_q;
    noev_d    = noev_q;
    best_d    = best_q;
    vic_d     = vic_q;
    vsize_d   = vsize_q;
    hidx_d    = hidx_q;
    ent_d     = ent_q;
    res_d     = res_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = pidx_q[IW-1:0];
    mem_wdata = alu_out.entry;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d   = req_i.key;
          size_d  = req_i.block_size;
          keep_d  = req_i.keep_flag;
          noev_d  = req_i.no_evict;
          res_d   = '0;
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (pend_q && alu_out.match) begin
          ent_d   = mem_rdata;
          hidx_d  = pidx_q[IW-1:0];
          pend_d  = 1'b0;
          state_d = S_BUMP;
        end else if (!pend_q && (k_q >= vcnt_q)) begin
          state_d = S_DECIDE;
        end
      end
      S_BUMP: begin
        mem_we        = 1'b1;
        mem_waddr     = hidx_q;
        res_d.hit     = 1'b1;
        res_d.offset  = ent_q.offset;
        res_d.length  = ent_q.length;
        state_d       = S_DONE;
      end
      S_DECIDE: begin
        k_d    = '0;
        pend_d = 1'b0;
        if (!keep_q || (size_q == '0)) begin
          state_d = S_DONE;
        end else if (short && !noev_q && (vcnt_q != '0)) begin
          state_d = S_SCAN;
        end else if ((vcnt_q < CW'(TABLE_ENTRIES)) && !short) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        // Strict less-than keeps the first entry among equal lowest counts.
        if (pend_q && ((pidx_q == '0) || alu_out.less)) begin
          best_d  = mem_rdata.hits;
          vic_d   = pidx_q;
          vsize_d = mem_rdata.length;
        end
        if (!pend_q && (k_q >= vcnt_q)) begin
          k_d     = '0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        mem_we = pend_q;
        if (!pend_q && (k_q >= issue_lim)) begin
          vcnt_d          = vcnt_q - CW'(1);
          used_d          = (used_q >= vsize_q) ? used_q - vsize_q : '0;
          res_d.evictions = res_q.evictions + EVC_W'(1);
          state_d         = S_DECIDE;
        end
      end
      S_APPEND: begin
        mem_we           = 1'b1;
        mem_waddr        = vcnt_q[IW-1:0];
        mem_wdata.key    = key_q;
        mem_wdata.length = size_q;
        mem_wdata.offset = used_q;
        mem_wdata.hits   = '0;
        vcnt_d           = vcnt_q + CW'(1);
        used_d           = used_q + size_q;
        res_d.stored     = 1'b1;
        res_d.offset     = used_q;
        res_d.length     = size_q;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!outv_q || rsp_o.ready) begin
          out_d   = res_q;
          outv_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q  <= '0;
      used_q  <= '0;
      cap_q   <= CAPACITY_RESET;
      k_q     <= '0;
      pend_q  <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
      used_q  <= used_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      outv_q  <= outv_d;
      if (cfg_wr && (paddr[APB_ADDR_W-1] == REG_CAPACITY)) begin
        cap_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    size_q  <= size_d;
    keep_q  <= keep_d;
    noev_q  <= noev_d;
    pidx_q  <= pidx_d;
    best_q  <= best_d;
    vic_q   <= vic_d;
    vsize_q <= vsize_d;
    hidx_q  <= hidx_d;
    ent_q   <= ent_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

FILE: rtl/fbt_mem.sv
module fbt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  fbt_pkg::ent_t  wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output fbt_pkg::ent_t  rdata_o
);
  import fbt_pkg::*;

  ent_t mem [DEPTH];
  ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fbt_alu.sv
module fbt_alu #(
  parameter int HIT_CEILING = 20
) (
  input  fbt_pkg::alu_in_t  in_i,
  output fbt_pkg::alu_out_t out_o
);
  import fbt_pkg::*;

  logic [HITS_W-1:0] aged;

  // Hit counts age toward zero and never wrap.
  assign aged = (in_i.entry.hits != '0) ? in_i.entry.hits - HITS_W'(1) : in_i.entry.hits;

  always_comb begin
    out_o.match = (in_i.entry.key == in_i.key);
    out_o.less  = (in_i.entry.hits < in_i.bound);
    out_o.entry = in_i.entry;
    case (in_i.op)
      OP_LOOK: begin
        out_o.entry = in_i.entry;
      end
      OP_BUMP: begin
        if (in_i.entry.hits < HITS_W'(HIT_CEILING)) begin
          out_o.entry.hits = in_i.entry.hits + HITS_W'(1);
        end
      end
      OP_AGE: begin
        out_o.entry.hits = aged;
      end
      OP_SHIFT: begin
        out_o.entry.offset = in_i.entry.offset - in_i.shift;
        out_o.entry.hits   = aged;
      end
      default: begin
        out_o.entry = in_i.entry;
      end
    endcase
  end

endmodule
